>>> rtl/core/sfd_pkg.sv
// shared types and constants of the serial frame deframer
`default_nettype none

package sfd_pkg;

   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
   localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
   localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;

   typedef logic [2:0] status_type;

   localparam status_type STATUS_BUSY    = 3'd0;
   localparam status_type STATUS_GOOD    = 3'd1;
   localparam status_type STATUS_BAD_CHK = 3'd2;
   localparam status_type STATUS_BAD_LEN = 3'd3;
   localparam status_type STATUS_BAD_HDR = 3'd4;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       data_valid;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/serial_frame_deframer.sv
// serial frame deframer top level: input stage, frame engine and result stage
// a byte is registered in the input stage, then its result in the engine's result register
// throughput: one byte per cycle with rsp_ready high, set by the state update
// rsp_ready low stalls a pending result and a full input stage behind it; req_ready stays high while a stage is free
// synchronous active-high reset returns to the header hunt with max_length 255
`default_nettype none

module serial_frame_deframer
   import sfd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_byte_in,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [7:0]              rsp_data_out,
   output logic                         rsp_data_valid,
   output status_type                   rsp_status,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready
);

   cfg_type    cfg;
   result_type result;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       out_load;
   logic       in_load;

   sfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign out_load  = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | out_load;
   assign in_load   = req_valid & req_ready;

   assign in_valid_in  = in_load | (in_valid_ff & ~out_load);
   assign out_valid_in = out_load | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_byte_in;
      end
   end

   sfd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .load    (out_load),
      .byte_in (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_data_out   = result.data_out;
   assign rsp_data_valid = result.data_valid;
   assign rsp_status     = result.status;

endmodule

`default_nettype wire

>>> rtl/core/sfd_csr.sv
// configuration registers behind the apb-style port
`default_nettype none

module sfd_csr
   import sfd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready,
   output cfg_type                      cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_HEADER_FIRST:  cfg_in.header_first  = csr_pwdata[7:0];
            REG_HEADER_SECOND: cfg_in.header_second = csr_pwdata[7:0];
            REG_MAX_LENGTH:    cfg_in.max_length    = csr_pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= 8'd0;
         cfg_ff.header_second <= 8'd0;
         cfg_ff.max_length    <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_HEADER_FIRST:  csr_prdata = {24'd0, cfg_ff.header_first};
         REG_HEADER_SECOND: csr_prdata = {24'd0, cfg_ff.header_second};
         REG_MAX_LENGTH:    csr_prdata = {24'd0, cfg_ff.max_length};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/sfd_engine.sv
// frame state machine with length count, xor check and result register
`default_nettype none

module sfd_engine
   import sfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire logic [7:0] byte_in,
   input  wire cfg_type    cfg,
   output result_type      result
);

   typedef enum logic [1:0] {
      PH_HEAD0 = 2'd0,
      PH_HEAD1 = 2'd1,
      PH_LEN   = 2'd2,
      PH_BODY  = 2'd3
   } phase_type;

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [7:0] remaining_ff;
   logic [7:0] remaining_in;
   logic [7:0] xor_sum_ff;
   logic [7:0] xor_sum_in;
   result_type result_ff;
   result_type result_in;
   logic [7:0] xor_next;

   assign xor_next = xor_sum_ff ^ byte_in;

   always_comb begin
      phase_in             = phase_ff;
      remaining_in         = remaining_ff;
      xor_sum_in           = xor_sum_ff;
      result_in.data_out   = 8'd0;
      result_in.data_valid = 1'b0;
      result_in.status     = STATUS_BUSY;
      unique case (phase_ff)
         PH_HEAD0: begin
            if (byte_in == cfg.header_first) begin
               phase_in     = PH_HEAD1;
               remaining_in = 8'd1;
            end
         end
         PH_HEAD1: begin
            remaining_in = 8'd1;
            if (byte_in == cfg.header_second) begin
               phase_in = PH_LEN;
            end else begin
               phase_in         = PH_HEAD0;
               result_in.status = STATUS_BAD_HDR;
            end
         end
         PH_LEN: begin
            if ((byte_in > 8'd1) && (byte_in <= cfg.max_length)) begin
               phase_in     = PH_BODY;
               remaining_in = byte_in;
               xor_sum_in   = 8'd0;
            end else begin
               phase_in         = PH_HEAD0;
               remaining_in     = 8'd1;
               result_in.status = STATUS_BAD_LEN;
            end
         end
         PH_BODY: begin
            xor_sum_in = xor_next;
            if (remaining_ff <= 8'd1) begin
               phase_in         = PH_HEAD0;
               remaining_in     = 8'd1;
               result_in.status = (xor_next == 8'd0) ? STATUS_GOOD : STATUS_BAD_CHK;
            end else begin
               remaining_in         = remaining_ff - 8'd1;
               result_in.data_out   = byte_in;
               result_in.data_valid = 1'b1;
            end
         end
         default: phase_in = PH_HEAD0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD0;
         remaining_ff <= 8'd1;
         xor_sum_ff   <= 8'd0;
      end else if (load) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         xor_sum_ff   <= xor_sum_in;
         result_ff    <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire
